>>> src/sas_pkg.sv
// Package for the square area sorter: payload types, control structs and state enums.
package sas_pkg;

   localparam int DEFAULT_CAPACITY = 64;
   localparam int COORD_W          = 16;
   localparam int LOAD_INDEX_W     = 6;
   localparam int AREA_W           = 33;
   localparam int MAG_W            = 16;
   localparam int SQ_W             = 32;
   localparam int ADDR_W           = 6;

   typedef struct packed {
      logic signed [COORD_W-1:0] ax;
      logic signed [COORD_W-1:0] ay;
      logic signed [COORD_W-1:0] bx;
      logic signed [COORD_W-1:0] by;
      logic                      final_item;
   } req_type;

   typedef struct packed {
      logic [LOAD_INDEX_W-1:0] load_index;
      logic [AREA_W-1:0]       area;
      logic                    end_of_run;
   } rsp_type;

   typedef struct packed {
      logic                    wr_en;
      logic [ADDR_W-1:0]       wr_addr;
      logic [AREA_W-1:0]       wr_area;
      logic [LOAD_INDEX_W-1:0] wr_index;
      logic                    rd_en;
      logic [ADDR_W-1:0]       rd_addr;
   } store_cmd_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_SQ_X,
      PH_SQ_Y,
      PH_SUM
   } area_phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AREA,
      ST_INS_RD,
      ST_INS_CMP,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } sorter_state_type;

endpackage

>>> src/sas_area_unit.sv
// Area key unit: one shared 16x16 multiplier squares dx, then dy, then sums them.
module sas_area_unit
   import sas_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  req_type           req_data,
   output logic              done,
   output logic [AREA_W-1:0] key
);

   area_phase_type     phase_ff, phase_in;
   logic [MAG_W-1:0]   dx_ff, dy_ff;
   logic [SQ_W-1:0]    mul_ff;
   logic [AREA_W-1:0]  acc_ff;
   logic               done_ff, done_in;
   logic [MAG_W:0]     diff_x, diff_y, neg_x, neg_y;
   logic [MAG_W-1:0]   mul_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      done_in  = 1'b0;
      case (phase_ff)
         PH_IDLE: if (start) phase_in = PH_SQ_X;
         PH_SQ_X: phase_in = PH_SQ_Y;
         PH_SQ_Y: phase_in = PH_SUM;
         PH_SUM: begin
            phase_in = PH_IDLE;
            done_in  = 1'b1;
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   assign diff_x = {req_data.ax[COORD_W-1], req_data.ax} - {req_data.bx[COORD_W-1], req_data.bx};
   assign diff_y = {req_data.ay[COORD_W-1], req_data.ay} - {req_data.by[COORD_W-1], req_data.by};
   assign neg_x  = -diff_x;
   assign neg_y  = -diff_y;
   assign mul_a  = (phase_ff == PH_SQ_X) ? dx_ff : dy_ff;

   always_ff @(posedge clock) begin
      if (phase_ff == PH_IDLE && start) begin
         dx_ff <= diff_x[MAG_W] ? neg_x[MAG_W-1:0] : diff_x[MAG_W-1:0];
         dy_ff <= diff_y[MAG_W] ? neg_y[MAG_W-1:0] : diff_y[MAG_W-1:0];
      end
      if (phase_ff == PH_SQ_X || phase_ff == PH_SQ_Y) begin
         mul_ff <= mul_a * mul_a;
      end
      if (phase_ff == PH_SQ_Y) begin
         acc_ff <= AREA_W'(mul_ff);
      end
      if (phase_ff == PH_SUM) begin
         acc_ff <= acc_ff + AREA_W'(mul_ff);
      end
   end

   assign done = done_ff;
   assign key  = acc_ff;

endmodule

>>> src/sas_store.sv
// Sorted store memory: area keys and load indices, one write and one registered read port.
module sas_store
   import sas_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
)(
   input  logic                    clock,
   input  store_cmd_type           cmd,
   output logic [AREA_W-1:0]       rd_area,
   output logic [LOAD_INDEX_W-1:0] rd_index
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic [AREA_W-1:0]       area_mem  [CAPACITY];
   logic [LOAD_INDEX_W-1:0] index_mem [CAPACITY];
   logic [AREA_W-1:0]       rd_area_ff;
   logic [LOAD_INDEX_W-1:0] rd_index_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         area_mem[cmd.wr_addr[IDX_W-1:0]]  <= cmd.wr_area;
         index_mem[cmd.wr_addr[IDX_W-1:0]] <= cmd.wr_index;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_area_ff  <= area_mem[cmd.rd_addr[IDX_W-1:0]];
         rd_index_ff <= index_mem[cmd.rd_addr[IDX_W-1:0]];
      end
   end

   assign rd_area  = rd_area_ff;
   assign rd_index = rd_index_ff;

endmodule

>>> src/square_area_sorter_top.sv
// Top level of the square area sorter: sequencer, area unit and sorted store.
//
//   channel | direction | handshake         | payload
//   req     | in        | req_valid/stall   | req_type: ax, ay, bx, by, final_item
//   rsp     | out       | rsp_valid/stall   | rsp_type: load_index, area, end_of_run
//
// A request first passes through the shared multiplier, then each stored entry
// with a larger key is shifted up one place before the key is placed.
// A final request then emits every result in order, held while rsp_stall is high.
// req_stall is high from acceptance until the request and its results are done.
// Synchronous reset empties the store; memory contents need no clearing.
module square_area_sorter_top
   import sas_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   sorter_state_type        state_ff, state_in;
   logic [CNT_W-1:0]        fill_ff, fill_in;
   logic [IDX_W-1:0]        pos_ff, pos_in;
   logic [IDX_W-1:0]        k_ff, k_in;
   logic                    eor_ff, eor_in;
   req_type                 req_ff;
   logic                    req_accept;
   logic                    area_done;
   logic [AREA_W-1:0]       key;
   logic [AREA_W-1:0]       rd_area;
   logic [LOAD_INDEX_W-1:0] rd_index;
   store_cmd_type           cmd;

   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_data;
      end
   end

   sas_area_unit u_area (
      .clock    (clock),
      .reset    (reset),
      .start    (req_accept),
      .req_data (req_data),
      .done     (area_done),
      .key      (key)
   );

   sas_store #(.CAPACITY(CAPACITY)) u_store (
      .clock    (clock),
      .cmd      (cmd),
      .rd_area  (rd_area),
      .rd_index (rd_index)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         pos_ff   <= '0;
         k_ff     <= '0;
         eor_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         pos_ff   <= pos_in;
         k_ff     <= k_in;
         eor_ff   <= eor_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      pos_in       = pos_ff;
      k_in         = k_ff;
      eor_in       = eor_ff;
      req_stall    = 1'b1;
      rsp_valid    = 1'b0;
      cmd          = '0;
      cmd.wr_area  = key;
      cmd.wr_index = LOAD_INDEX_W'(fill_ff);
      cmd.wr_addr  = ADDR_W'(pos_ff);
      cmd.rd_addr  = ADDR_W'(pos_ff - IDX_W'(1));
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) state_in = ST_AREA;
         end
         ST_AREA: begin
            if (area_done) begin
               if (fill_ff == CNT_W'(CAPACITY)) begin
                  k_in     = '0;
                  state_in = req_ff.final_item ? ST_EMIT_RD : ST_IDLE;
               end else begin
                  pos_in   = IDX_W'(fill_ff);
                  state_in = ST_INS_RD;
               end
            end
         end
         ST_INS_RD: begin
            if (pos_ff == '0) begin
               cmd.wr_en = 1'b1;
               fill_in   = fill_ff + CNT_W'(1);
               k_in      = '0;
               state_in  = req_ff.final_item ? ST_EMIT_RD : ST_IDLE;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            cmd.wr_en = 1'b1;
            if (rd_area > key) begin
               cmd.wr_area  = rd_area;
               cmd.wr_index = rd_index;
               pos_in       = pos_ff - IDX_W'(1);
               state_in     = ST_INS_RD;
            end else begin
               fill_in  = fill_ff + CNT_W'(1);
               k_in     = '0;
               state_in = req_ff.final_item ? ST_EMIT_RD : ST_IDLE;
            end
         end
         ST_EMIT_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = ADDR_W'(k_ff);
            eor_in      = (CNT_W'(k_ff) + CNT_W'(1)) == fill_ff;
            state_in    = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (eor_ff) begin
                  fill_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + IDX_W'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_data.load_index = rd_index;
   assign rsp_data.area       = rd_area;
   assign rsp_data.end_of_run = eor_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(CAPACITY))
      else $error("fill count exceeds capacity");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("request accepted while previous request in progress");

   a_run_empties: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.end_of_run) |=> (fill_ff == '0))
      else $error("store not emptied after end of run");

   a_no_rsp_during_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_AREA || state_ff == ST_INS_RD || state_ff == ST_INS_CMP)
      |-> !rsp_valid)
      else $error("response during insertion");

endmodule
